/* sv/pbmi_pkg.sv */
// ----------------------------------------------------------------------------
// pbmi_pkg - shared types and constants for the packet byte mark inserter
// Register indices, reset values and the queue entry / config bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbmi_pkg;

  localparam int unsigned MAX_MARKS  = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PLACED_W   = 3;
  localparam int unsigned MIDX_W     = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_MARK_BYTE_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_BYTE_1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_BYTE_2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_BYTE_3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_POS_0  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_POS_1  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_POS_2  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_POS_3  = 4'd7;

  // Reset values
  localparam logic [BYTE_W-1:0] RST_MARK_BYTE_0 = 8'h73;
  localparam logic [BYTE_W-1:0] RST_MARK_BYTE_1 = 8'h6a;
  localparam logic [BYTE_W-1:0] RST_MARK_BYTE_2 = 8'h73;
  localparam logic [BYTE_W-1:0] RST_MARK_BYTE_3 = 8'h75;
  localparam logic [POS_W-1:0]  RST_MARK_POS_0  = 16'd70;
  localparam logic [POS_W-1:0]  RST_MARK_POS_1  = 16'd65;
  localparam logic [POS_W-1:0]  RST_MARK_POS_2  = 16'd60;
  localparam logic [POS_W-1:0]  RST_MARK_POS_3  = 16'd55;

  localparam logic [POS_W-1:0]  COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } entry_t;

  typedef struct packed {
    logic [MAX_MARKS-1:0][BYTE_W-1:0] mark_byte;
    logic [MAX_MARKS-1:0][POS_W-1:0]  mark_pos;
  } mark_cfg_t;

endpackage

`default_nettype wire

/* sv/pbmi_cfg.sv */
// ----------------------------------------------------------------------------
// pbmi_cfg - mark configuration registers
// Four mark bytes and four output offsets, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmi_cfg
  import pbmi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output mark_cfg_t                  mark_cfg
);

  mark_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_byte[0] <= RST_MARK_BYTE_0;
      cfg_r.mark_byte[1] <= RST_MARK_BYTE_1;
      cfg_r.mark_byte[2] <= RST_MARK_BYTE_2;
      cfg_r.mark_byte[3] <= RST_MARK_BYTE_3;
      cfg_r.mark_pos[0]  <= RST_MARK_POS_0;
      cfg_r.mark_pos[1]  <= RST_MARK_POS_1;
      cfg_r.mark_pos[2]  <= RST_MARK_POS_2;
      cfg_r.mark_pos[3]  <= RST_MARK_POS_3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MARK_BYTE_0: cfg_r.mark_byte[0] <= cfg_wdata[BYTE_W-1:0];
        REG_MARK_BYTE_1: cfg_r.mark_byte[1] <= cfg_wdata[BYTE_W-1:0];
        REG_MARK_BYTE_2: cfg_r.mark_byte[2] <= cfg_wdata[BYTE_W-1:0];
        REG_MARK_BYTE_3: cfg_r.mark_byte[3] <= cfg_wdata[BYTE_W-1:0];
        REG_MARK_POS_0:  cfg_r.mark_pos[0]  <= cfg_wdata[POS_W-1:0];
        REG_MARK_POS_1:  cfg_r.mark_pos[1]  <= cfg_wdata[POS_W-1:0];
        REG_MARK_POS_2:  cfg_r.mark_pos[2]  <= cfg_wdata[POS_W-1:0];
        REG_MARK_POS_3:  cfg_r.mark_pos[3]  <= cfg_wdata[POS_W-1:0];
        default: ; // unknown index: ignored
      endcase
    end
  end

  assign mark_cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/pbmi_queue.sv */
// ----------------------------------------------------------------------------
// pbmi_queue - front end: accepts input requests into a short queue
// Stalls the input only when full, so the back end can pause for marks.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmi_queue
  import pbmi_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   head_valid,
  output entry_t                 head,
  input  wire logic              pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push, do_pop;

  assign in_stall   = (fill_r == FULL_CNT);
  assign push       = in_valid && !in_stall;
  assign head_valid = (fill_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !do_pop) fill_nxt = fill_r + CNT_W'(1);
    else if (!push && do_pop) fill_nxt = fill_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= '{data_byte: in_data_byte, last_byte: in_last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/pbmi_back.sv */
// ----------------------------------------------------------------------------
// pbmi_back - back end: mark sequencer and output register
// A byte per cycle unless stalled: data with marks at offsets, then the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module pbmi_back
  import pbmi_pkg::*;
#(
  parameter int unsigned NUM_MARKS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mark_cfg_t         mark_cfg,
  input  wire logic              head_valid,
  input  wire entry_t            head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_is_mark,
  output logic                   out_packet_end,
  output logic                   out_run_end
);

  localparam logic [PLACED_W-1:0] NUM_P  = PLACED_W'(NUM_MARKS);
  localparam logic [PLACED_W-1:0] LAST_P = PLACED_W'(NUM_MARKS - 1);

  typedef enum logic {PH_DATA, PH_TRAIL} phase_t;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    count_r, count_nxt, count_inc;
  logic [PLACED_W-1:0] placed_r, placed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic                mark_r, mark_nxt, pend_r, pend_nxt, rend_r, rend_nxt;
  logic                advance, pending, hit;
  logic [MIDX_W-1:0]   midx;

  assign advance   = !out_valid_r || !out_stall;
  assign pending   = (placed_r < NUM_P);
  assign midx      = MIDX_W'(LAST_P - placed_r);
  assign hit       = pending && (mark_cfg.mark_pos[midx] == count_r);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + POS_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    placed_nxt    = placed_r;
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    mark_nxt      = mark_r;
    pend_nxt      = pend_r;
    rend_nxt      = rend_r;
    pop           = 1'b0;
    if (advance) begin
      case (phase_r)
        PH_TRAIL: begin
          out_valid_nxt = 1'b1;
          byte_nxt      = mark_cfg.mark_byte[midx];
          mark_nxt      = 1'b1;
          if (placed_r == LAST_P) begin
            pend_nxt   = 1'b1;
            rend_nxt   = 1'b1;
            count_nxt  = '0;
            placed_nxt = '0;
            phase_nxt  = PH_DATA;
          end else begin
            pend_nxt   = 1'b0;
            rend_nxt   = 1'b0;
            count_nxt  = count_inc;
            placed_nxt = placed_r + PLACED_W'(1);
          end
        end
        PH_DATA: begin
          if (head_valid) begin
            out_valid_nxt = 1'b1;
            if (hit) begin
              byte_nxt   = mark_cfg.mark_byte[midx];
              mark_nxt   = 1'b1;
              pend_nxt   = 1'b0;
              rend_nxt   = 1'b0;
              count_nxt  = count_inc;
              placed_nxt = placed_r + PLACED_W'(1);
            end else begin
              pop      = 1'b1;
              byte_nxt = head.data_byte;
              mark_nxt = 1'b0;
              if (head.last_byte && pending) begin
                // marks not yet placed follow the last data byte
                pend_nxt  = 1'b0;
                rend_nxt  = 1'b0;
                count_nxt = count_inc;
                phase_nxt = PH_TRAIL;
              end else if (head.last_byte) begin
                pend_nxt   = 1'b1;
                rend_nxt   = 1'b1;
                count_nxt  = '0;
                placed_nxt = '0;
              end else begin
                pend_nxt  = 1'b0;
                rend_nxt  = 1'b1;
                count_nxt = count_inc;
              end
            end
          end
        end
        default: phase_nxt = PH_DATA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      count_r     <= '0;
      placed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r <= byte_nxt;
    mark_r <= mark_nxt;
    pend_r <= pend_nxt;
    rend_r <= rend_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_is_mark    = mark_r;
  assign out_packet_end = pend_r;
  assign out_run_end    = rend_r;

endmodule

`default_nettype wire

/* sv/packet_byte_mark_inserter_top.sv */
// ----------------------------------------------------------------------------
// packet_byte_mark_inserter_top - inserts configured mark bytes into packets
// Input byte stream with end-of-packet flag; marked byte stream out.
// ----------------------------------------------------------------------------
// Usage notes:
//   Input channel (in_*): one packet byte per request, in_last_byte on the
//   final byte. Requests go into a short queue; in_stall rises only when
//   the queue is full.
//   Output channel (out_*): one byte per request. out_is_mark flags an
//   inserted mark, out_packet_end the final byte of the grown packet and
//   out_run_end the last byte caused by a given input request.
//   Config port (cfg_*): single-cycle writes, index 0..3 mark bytes,
//   4..7 mark positions; other indices are ignored. Write only when idle.
//   Path: an input request is registered in the queue, then in the output
//   register. Throughput: one output byte per cycle while out_stall is low,
//   set by the back-end sequencer; an input byte yields its own byte plus
//   each mark inserted before or after it, so N bytes grow to N + NUM_MARKS.
//   Reset (rst_n low, synchronous) empties the queue, clears the counts
//   and restores the default marks. A stalled output holds its byte while
//   the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_byte_mark_inserter_top
  import pbmi_pkg::*;
#(
  parameter int unsigned NUM_MARKS   = 4,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  input  wire logic                  in_last_byte,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [BYTE_W-1:0]          out_byte,
  output logic                       out_is_mark,
  output logic                       out_packet_end,
  output logic                       out_run_end,
  // config port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  mark_cfg_t mark_cfg;
  entry_t    head;
  logic      head_valid, pop;

  pbmi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mark_cfg  (mark_cfg)
  );

  // front: accept and queue requests
  pbmi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  // back: mark placement and output register
  pbmi_back #(.NUM_MARKS(NUM_MARKS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mark_cfg       (mark_cfg),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_mark    (out_is_mark),
    .out_packet_end (out_packet_end),
    .out_run_end    (out_run_end)
  );

endmodule

`default_nettype wire
